// ===== src/scmd_pkg.sv =====
// Shared types, constants and register codes for the stereo chorus block.
package scmd_pkg;

    // Default sizing of the delay lines and samples
    localparam int DELAY_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register field widths
    localparam int RATE_W  = 16;
    localparam int DEPTH_W = 16;
    localparam int MIX_W   = 16;
    localparam int SR_W    = 18;

    // Derived term widths
    localparam int BASE_W   = 28;
    localparam int SWEEP_W  = 27;
    localparam int PHASE_W  = 32;
    localparam int MAG_W    = 31;
    localparam int PAR_W    = 29;
    localparam int OFF_W    = 29;
    localparam int DLY_W    = 34;
    localparam int FRAC_W   = 16;

    // Serial divider widths
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 45;

    // Sample rate limits
    localparam logic [SR_W-1:0] SR_MIN = 18'd8000;
    localparam logic [SR_W-1:0] SR_MAX = 18'd192000;

    // Refinement weight 0.225 in Q16
    localparam logic [14:0] REFINE_Q16 = 15'd14746;

    // Register reset values
    localparam logic [RATE_W-1:0]  RATE_RST  = 16'd19661;
    localparam logic [DEPTH_W-1:0] DEPTH_RST = 16'd32768;
    localparam logic [MIX_W-1:0]   MIX_RST   = 16'd32768;
    localparam logic [SR_W-1:0]    SR_RST    = 18'd48000;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_RATE   = 3'd0,
        REG_DEPTH  = 3'd1,
        REG_MIX    = 3'd2,
        REG_SR     = 3'd3,
        REG_IN_ST  = 3'd4,
        REG_OUT_ST = 3'd5
    } t_reg_idx;

    // Derived-term sequencer
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_BASE,
        SEQ_SWEEP,
        SEQ_INC
    } t_seq_state;

    // Per-frame datapath sequencer
    typedef enum logic [3:0] {
        DP_IDLE,
        DP_ABS,
        DP_SQ,
        DP_REF,
        DP_CORR,
        DP_OFF,
        DP_POS,
        DP_RD0,
        DP_RD1,
        DP_RD2,
        DP_INTERP,
        DP_MIX_A,
        DP_MIX_B,
        DP_FIN
    } t_dp_state;

    // Settings and derived terms handed to the datapath
    typedef struct packed {
        logic               busy;
        logic [MIX_W-1:0]   mix;
        logic               in_stereo;
        logic               out_stereo;
        logic [BASE_W-1:0]  base;
        logic [SWEEP_W-1:0] sweep;
        logic [PHASE_W-1:0] inc;
    } t_cfg;

endpackage

// ===== src/scmd_if.sv =====
// Stream interfaces for input frames and result frames.
interface scmd_in_if
    import scmd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface scmd_out_if
    import scmd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ===== src/stereo_chorus_modulated_delay.sv =====
// Stereo chorus top level: frame sequencer, LFO and delay datapath, delay lines.
// A result becomes valid only after both channels of the accepted frame are finished.
// The block takes no new frame until the last one is finished; one read port per
// delay line, two channels handled in turn, 12 steps each.
// Reset: delay lines read as zero until written (fill count, no clearing pass).
// After reset and after each register write the input stalls while a 64-step
// serial divider recomputes the rate increment.
module stereo_chorus_modulated_delay
    import scmd_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    scmd_in_if.sink            i_in,
    scmd_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int SB = SAMPLE_BITS;
    localparam logic signed [DLY_W-1:0] D_LO   = DLY_W'(longint'(65536));
    localparam logic signed [DLY_W-1:0] D_HI   =
        DLY_W'(longint'(DELAY_DEPTH - 2) * 64'sd65536);
    localparam logic signed [DLY_W-1:0] D_WRAP =
        DLY_W'(longint'(DELAY_DEPTH) * 64'sd65536);
    localparam logic signed [SB+17:0] IP_HALF = (SB+18)'(32768);
    localparam logic signed [SB+19:0] MX_HALF = (SB+20)'(32768);

    t_cfg        cfg;
    t_dp_state   r_state;
    t_dp_state   n_state;

    logic        r_ch;
    logic [AW-1:0] r_widx;
    logic [AW:0]   r_fill;
    logic [PHASE_W-1:0] r_phase;
    logic        r_ovalid;
    logic signed [SB-1:0] r_oleft;
    logic signed [SB-1:0] r_oright;

    logic signed [SB-1:0] r_xl;
    logic signed [SB-1:0] r_xr;
    logic [PHASE_W-1:0]   r_a;
    logic                 r_neg;
    logic [MAG_W-1:0]     r_m;
    logic [PAR_W-1:0]     r_p;
    logic [OFF_W-1:0]     r_off;
    logic [AW-1:0]        r_i0;
    logic [AW-1:0]        r_i1;
    logic [FRAC_W-1:0]    r_f;
    logic                 r_v0;
    logic                 r_v1;
    logic signed [SB-1:0] r_b0;
    logic signed [SB-1:0] r_b1;
    logic signed [SB+1:0] r_wet;
    logic signed [SB+19:0] r_acc;
    logic signed [SB:0]   r_yl;
    logic signed [SB:0]   r_yr;

    logic        in_rdy;
    logic        accept;
    logic        fin_load;
    logic        ram_re;
    logic [AW-1:0] ram_raddr;
    logic signed [SB-1:0] x_r_in;
    logic [SB-1:0] rdata_l;
    logic [SB-1:0] rdata_r;
    logic signed [SB-1:0] rdata_ch;
    logic        rd_valid;

    logic [PHASE_W-1:0] lfo_u;
    logic [63:0]        sq_prod;
    logic [33:0]        sq_m;
    logic [MAG_W-1:0]   ref_one_m;
    logic [61:0]        ref_prod;
    logic [43:0]        corr_prod;
    logic [58:0]        off_prod;
    logic signed [DLY_W-1:0] d_raw;
    logic signed [DLY_W-1:0] d_clamp;
    logic signed [DLY_W-1:0] pos_raw;
    logic signed [DLY_W-1:0] pos;
    logic [AW-1:0]      pos_i0;
    logic signed [SB:0]    ip_diff;
    logic signed [16:0]    ip_f;
    logic signed [SB+17:0] ip_prod;
    logic signed [SB+17:0] ip_sum;
    logic signed [SB+1:0]  ip_sh;
    logic signed [SB-1:0]  x_sel;
    logic signed [17:0]    mx_dry;
    logic signed [16:0]    mx_wet;
    logic signed [SB+19:0] mx_xd;
    logic signed [SB+19:0] mx_wm;
    logic signed [SB+19:0] mx_sum;
    logic signed [SB+1:0]  avg_sum;

    // settings and derived terms
    scmd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign accept = i_in.valid & in_rdy;
    assign x_r_in = cfg.in_stereo ? i_in.in_right : i_in.in_left;

    // delay lines
    scmd_ram #(.DEPTH(DELAY_DEPTH), .WIDTH(SB)) u_line_l (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_widx),
        .i_wdata (i_in.in_left),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata_l)
    );

    scmd_ram #(.DEPTH(DELAY_DEPTH), .WIDTH(SB)) u_line_r (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_widx),
        .i_wdata (x_r_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata_r)
    );

    assign rdata_ch = r_ch ? $signed(rdata_r) : $signed(rdata_l);
    assign rd_valid = ({1'b0, ram_raddr} < r_fill);

    // sequencer next state and strobes
    always_comb begin
        n_state   = r_state;
        in_rdy    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_i0;
        fin_load  = 1'b0;
        unique case (r_state)
            DP_IDLE: begin
                in_rdy = ~cfg.busy;
                if (i_in.valid && !cfg.busy) begin
                    n_state = DP_ABS;
                end
            end
            DP_ABS:    n_state = DP_SQ;
            DP_SQ:     n_state = DP_REF;
            DP_REF:    n_state = DP_CORR;
            DP_CORR:   n_state = DP_OFF;
            DP_OFF:    n_state = DP_POS;
            DP_POS:    n_state = DP_RD0;
            DP_RD0: begin
                ram_re  = 1'b1;
                n_state = DP_RD1;
            end
            DP_RD1: begin
                ram_re    = 1'b1;
                ram_raddr = r_i1;
                n_state   = DP_RD2;
            end
            DP_RD2:    n_state = DP_INTERP;
            DP_INTERP: n_state = DP_MIX_A;
            DP_MIX_A:  n_state = DP_MIX_B;
            DP_MIX_B:  n_state = r_ch ? DP_FIN : DP_ABS;
            DP_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    fin_load = 1'b1;
                    n_state  = DP_IDLE;
                end
            end
            default: n_state = DP_IDLE;
        endcase
    end

    // LFO: parabola, refinement, then delay offset
    always_comb begin
        lfo_u     = r_phase - (r_ch ? 32'h4000_0000 : 32'h8000_0000);
        sq_prod   = 64'(r_a) * 64'(r_a);
        sq_m      = {1'b0, r_a, 1'b0} - sq_prod[63:30];
        ref_one_m = MAG_W'(32'h4000_0000) - r_m;
        ref_prod  = 62'(r_m) * 62'(ref_one_m);
        corr_prod = 44'(r_p) * 44'(REFINE_Q16) + 44'd32768;
        off_prod  = 59'(cfg.sweep) * 59'(r_m) + 59'(32'h2000_0000);
    end

    // delay clamp and read position
    always_comb begin
        if (r_neg) begin
            d_raw = DLY_W'(cfg.base) - DLY_W'(r_off);
        end else begin
            d_raw = DLY_W'(cfg.base) + DLY_W'(r_off);
        end
        priority if (d_raw < D_LO) begin
            d_clamp = D_LO;
        end else if (d_raw > D_HI) begin
            d_clamp = D_HI;
        end else begin
            d_clamp = d_raw;
        end
        pos_raw = $signed({(DLY_W-AW-16)'(0), r_widx, 16'h0000}) - d_clamp;
        pos     = (pos_raw < 0) ? pos_raw + D_WRAP : pos_raw;
        pos_i0  = pos[AW+15:16];
    end

    // interpolation and mix
    always_comb begin
        ip_diff = {r_b1[SB-1], r_b1} - {r_b0[SB-1], r_b0};
        ip_f    = {1'b0, r_f};
        ip_prod = ip_diff * ip_f;
        ip_sum  = ip_prod + IP_HALF;
        ip_sh   = ip_sum[SB+17:16];
        x_sel   = r_ch ? r_xr : r_xl;
        mx_dry  = $signed(18'd65536 - {2'b00, cfg.mix});
        mx_wet  = $signed({1'b0, cfg.mix});
        mx_xd   = x_sel * mx_dry;
        mx_wm   = r_wet * mx_wet;
        mx_sum  = r_acc + mx_wm + MX_HALF;
        avg_sum = {r_yl[SB], r_yl} + {r_yr[SB], r_yr} + (SB+2)'(1);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= DP_IDLE;
            r_ch     <= 1'b0;
            r_widx   <= '0;
            r_fill   <= '0;
            r_phase  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_ch <= 1'b0;
                if (r_fill != (AW+1)'(DELAY_DEPTH)) begin
                    r_fill <= r_fill + (AW+1)'(1);
                end
            end else if (r_state == DP_MIX_B) begin
                r_ch <= ~r_ch;
            end
            if (fin_load) begin
                r_ovalid <= 1'b1;
                r_phase  <= r_phase + cfg.inc;
                r_widx   <= (r_widx == AW'(DELAY_DEPTH - 1)) ? '0 : r_widx + AW'(1);
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_xl <= i_in.in_left;
            r_xr <= x_r_in;
        end
        unique case (r_state)
            DP_ABS: begin
                r_neg <= lfo_u[PHASE_W-1];
                r_a   <= lfo_u[PHASE_W-1] ? (32'h0 - lfo_u) : lfo_u;
            end
            DP_SQ:   r_m <= sq_m[MAG_W-1:0];
            DP_REF:  r_p <= ref_prod[58:30];
            DP_CORR: r_m <= r_m - MAG_W'(corr_prod[43:16]);
            DP_OFF:  r_off <= off_prod[58:30];
            DP_POS: begin
                r_i0 <= pos_i0;
                r_i1 <= (pos_i0 == AW'(DELAY_DEPTH - 1)) ? '0 : pos_i0 + AW'(1);
                r_f  <= pos[15:0];
            end
            DP_RD0: r_v0 <= rd_valid;
            DP_RD1: begin
                r_v1 <= rd_valid;
                r_b0 <= r_v0 ? rdata_ch : '0;
            end
            DP_RD2:    r_b1 <= r_v1 ? rdata_ch : '0;
            DP_INTERP: r_wet <= {{2{r_b0[SB-1]}}, r_b0} + ip_sh;
            DP_MIX_A:  r_acc <= mx_xd;
            DP_MIX_B: begin
                if (r_ch) begin
                    r_yr <= mx_sum[SB+16:16];
                end else begin
                    r_yl <= mx_sum[SB+16:16];
                end
            end
            DP_FIN: begin
                if (fin_load) begin
                    r_oleft  <= cfg.out_stereo ? r_yl[SB-1:0] : avg_sum[SB:1];
                    r_oright <= cfg.out_stereo ? r_yr[SB-1:0] : avg_sum[SB:1];
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready      = in_rdy;
    assign o_out.valid     = r_ovalid;
    assign o_out.out_left  = r_oleft;
    assign o_out.out_right = r_oright;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (AW+1)'(DELAY_DEPTH))
        else $error("fill count beyond line depth");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == DP_ABS) && !r_ch)
        else $error("accepted frame did not start on left channel");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == DP_FIN)
        else $error("result valid without finished frame");

    a_widx_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_load |=> r_widx != $past(r_widx))
        else $error("write index did not advance");
`endif

endmodule

// ===== src/scmd_ram.sv =====
// Simple dual-port delay line memory with registered read data.
module scmd_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/scmd_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module scmd_div
    import scmd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_q;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;
    logic [DIV_DEN_W-1:0] n_rem;

    // one trial subtraction per step
    always_comb begin
        trial = {r_rem, r_q[DIV_NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_NUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== src/scmd_regs.sv =====
// Configuration registers and sequencer for the derived delay and rate terms.
module scmd_regs
    import scmd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    // steps of the divide-by-1000 pipeline
    localparam logic [1:0]  STEP_NUM   = 2'd0;
    localparam logic [1:0]  STEP_RED   = 2'd1;
    localparam logic [1:0]  STEP_LAST  = 2'd2;
    // ceil(2^37 / 1000); exact for reduced terms below about 2.6e8
    localparam logic [27:0] RECIP_1000 = 28'd137438954;

    logic [RATE_W-1:0]  r_rate;
    logic [DEPTH_W-1:0] r_depth;
    logic [MIX_W-1:0]   r_mix;
    logic [SR_W-1:0]    r_sr;
    logic               r_in_st;
    logic               r_out_st;

    logic               r_dirty;
    t_seq_state         r_seq;
    t_seq_state         n_seq;
    logic [1:0]         r_step;
    logic [BASE_W-1:0]  r_base;
    logic [SWEEP_W-1:0] r_sweep;
    logic [PHASE_W-1:0] r_inc;

    logic [37:0]        r_dnum;
    logic [27:0]        r_dred;
    logic [27:0]        r_dhq;
    logic [55:0]        red_prod;
    logic [27:0]        red_quo;

    logic               wr;
    t_reg_idx           idx;
    logic [SR_W-1:0]    sr_sat;
    logic [19:0]        sweep_mul;
    logic [28:0]        rate_term;
    logic [37:0]        base_num;
    logic [37:0]        sweep_num;
    logic [DIV_NUM_W-1:0] inc_num;
    logic [DIV_DEN_W-1:0] inc_den;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[4:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_RST;
            r_depth  <= DEPTH_RST;
            r_mix    <= MIX_RST;
            r_sr     <= SR_RST;
            r_in_st  <= 1'b1;
            r_out_st <= 1'b1;
        end else if (wr) begin
            unique case (idx)
                REG_RATE:   r_rate   <= pwdata[RATE_W-1:0];
                REG_DEPTH:  r_depth  <= pwdata[DEPTH_W-1:0];
                REG_MIX:    r_mix    <= pwdata[MIX_W-1:0];
                REG_SR:     r_sr     <= pwdata[SR_W-1:0];
                REG_IN_ST:  r_in_st  <= pwdata[0];
                REG_OUT_ST: r_out_st <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (idx)
            REG_RATE:   prdata = PDATA_W'(r_rate);
            REG_DEPTH:  prdata = PDATA_W'(r_depth);
            REG_MIX:    prdata = PDATA_W'(r_mix);
            REG_SR:     prdata = PDATA_W'(r_sr);
            REG_IN_ST:  prdata = PDATA_W'(r_in_st);
            REG_OUT_ST: prdata = PDATA_W'(r_out_st);
            default:    prdata = '0;
        endcase
    end

    // dividend and divisor terms
    always_comb begin
        if (r_sr < SR_MIN) begin
            sr_sat = SR_MIN;
        end else if (r_sr > SR_MAX) begin
            sr_sat = SR_MAX;
        end else begin
            sr_sat = r_sr;
        end
        sweep_mul = 20'd65536 + {1'b0, r_depth, 3'b000};
        rate_term = 29'd3276800 + 29'(r_rate) * 29'd5950;
        base_num  = 38'(sr_sat) * 38'd786432 + 38'd500;
        sweep_num = 38'(sr_sat) * 38'(sweep_mul) + 38'd500;
        inc_den   = DIV_DEN_W'(sr_sat) * DIV_DEN_W'(65536000);
        inc_num   = {3'b000, rate_term, 32'h0} + DIV_NUM_W'(inc_den >> 1);
        div_num   = inc_num;
        div_den   = inc_den;
    end

    // divide by 1000: N = H*2^20 + L = H*1048*1000 + (H*576 + L)
    always_comb begin
        red_prod = 56'(r_dred) * 56'(RECIP_1000);
        red_quo  = r_dhq + 28'(red_prod[55:37]);
    end

    // sequencer: rate divide runs while base and sweep are reduced
    always_comb begin
        n_seq     = r_seq;
        div_start = 1'b0;
        unique case (r_seq)
            SEQ_IDLE: begin
                if (r_dirty) begin
                    div_start = 1'b1;
                    n_seq     = SEQ_BASE;
                end
            end
            SEQ_BASE: begin
                if (r_step == STEP_LAST) begin
                    n_seq = SEQ_SWEEP;
                end
            end
            SEQ_SWEEP: begin
                if (r_step == STEP_LAST) begin
                    n_seq = SEQ_INC;
                end
            end
            SEQ_INC: begin
                if (div_done) begin
                    n_seq = SEQ_IDLE;
                end
            end
            default: n_seq = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= SEQ_IDLE;
            r_step  <= STEP_NUM;
            r_dirty <= 1'b1;
        end else begin
            r_seq <= n_seq;
            if ((r_seq == SEQ_BASE || r_seq == SEQ_SWEEP) && r_step != STEP_LAST) begin
                r_step <= r_step + 2'd1;
            end else begin
                r_step <= STEP_NUM;
            end
            if (wr) begin
                r_dirty <= 1'b1;
            end else if (r_seq == SEQ_IDLE) begin
                r_dirty <= 0;
            end
        end
    end

    // reduction pipeline and quotient capture
    always_ff @(posedge i_clk) begin
        if (r_seq == SEQ_BASE || r_seq == SEQ_SWEEP) begin
            unique case (r_step)
                STEP_NUM: r_dnum <= (r_seq == SEQ_BASE) ? base_num : sweep_num;
                STEP_RED: begin
                    r_dred <= 28'(r_dnum[37:20]) * 28'd576 + 28'(r_dnum[19:0]);
                    r_dhq  <= 28'(r_dnum[37:20]) * 28'd1048;
                end
                default: begin
                    if (r_seq == SEQ_BASE) begin
                        r_base <= red_quo;
                    end else begin
                        r_sweep <= red_quo[SWEEP_W-1:0];
                    end
                end
            endcase
        end
        if (div_done && r_seq == SEQ_INC) begin
            r_inc <= div_quo[PHASE_W-1:0];
        end
    end

    scmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_cfg.busy       = r_dirty | (r_seq != SEQ_IDLE);
    assign o_cfg.mix        = r_mix;
    assign o_cfg.in_stereo  = r_in_st;
    assign o_cfg.out_stereo = r_out_st;
    assign o_cfg.base       = r_base;
    assign o_cfg.sweep      = r_sweep;
    assign o_cfg.inc        = r_inc;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the stereo chorus block with a built-in frame predictor.
`timescale 1ns / 100ps

module testbench;
    import scmd_pkg::*;

    localparam int LINE_LEN = 4096;
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_frame;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    scmd_in_if  #(.SAMPLE_BITS(16)) in_if ();
    scmd_out_if #(.SAMPLE_BITS(16)) out_if ();

    stereo_chorus_modulated_delay dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor copy of registers and state
    logic [15:0] rate_q, depth_q, mix_q;
    logic [17:0] srate_q;
    logic        in_st_q, out_st_q;
    logic signed [15:0] echo_l [0:LINE_LEN-1];
    logic signed [15:0] echo_r [0:LINE_LEN-1];
    logic [11:0] wr_ptr;
    logic [31:0] lfo_acc;

    t_frame frames_todo[$];
    t_frame chorus_due[$];
    int errors = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_cfg  = 0;
    bit calm   = 1'b0;   // no random gaps on either side while set; the receiver hold-off still applies

    function automatic longint rshift_rnd(longint v, int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    // Parabolic sine with one refinement pass, Q30
    function automatic longint sine_q30(logic [31:0] turn);
        longint u, m;
        longint unsigned a, p;
        u = longint'($signed(turn));
        a = (u < 0) ? -u : u;
        m = 2 * a - ((a * a) >> 30);
        p = (m * ((64'sd1 <<< 30) - m)) >> 30;
        m = m - ((p * 14746 + 32768) >> 16);
        return (u < 0) ? -m : m;
    endfunction

    function automatic longint tap_delay(longint base, longint sweep, longint lfo);
        longint unsigned mag, off;
        longint d;
        mag = (lfo < 0) ? -lfo : lfo;
        off = (sweep * mag + (64'd1 << 29)) >> 30;
        d = (lfo < 0) ? base - longint'(off) : base + longint'(off);
        if (d < (64'sd1 <<< 16)) d = 64'sd1 <<< 16;
        if (d > (longint'(LINE_LEN - 2) <<< 16)) d = longint'(LINE_LEN - 2) <<< 16;
        return d;
    endfunction

    function automatic longint tap_read(bit right_ch, longint d);
        longint pos, f, b0, b1;
        int i0;
        pos = (longint'(wr_ptr) <<< 16) - d;
        if (pos < 0) pos += longint'(LINE_LEN) <<< 16;
        i0 = int'((pos >>> 16) % LINE_LEN);
        f = pos & 64'hFFFF;
        b0 = right_ch ? echo_r[i0] : echo_l[i0];
        b1 = right_ch ? echo_r[(i0 + 1) % LINE_LEN] : echo_l[(i0 + 1) % LINE_LEN];
        return b0 + rshift_rnd((b1 - b0) * f, 16);
    endfunction

    // Advance the chorus model by one frame and queue its output
    function automatic void chorus_frame(t_frame x);
        longint unsigned sr, num, den, inc;
        longint xl, xr, base, sweep, wl, wr, wet, dry, yl, yr;
        t_frame y;
        sr = srate_q;
        if (sr < 8000) sr = 8000;
        if (sr > 192000) sr = 192000;
        xl = x.left;
        xr = in_st_q ? longint'(x.right) : xl;
        echo_l[wr_ptr] = xl[15:0];
        echo_r[wr_ptr] = xr[15:0];
        base  = (sr * 12 * 65536 + 500) / 1000;
        sweep = (sr * (65536 + 8 * longint'(depth_q)) + 500) / 1000;
        wl = tap_read(1'b0, tap_delay(base, sweep, sine_q30(lfo_acc - 32'h8000_0000)));
        wr = tap_read(1'b1, tap_delay(base, sweep, sine_q30(lfo_acc - 32'h4000_0000)));
        wet = mix_q;
        dry = 65536 - wet;
        yl = rshift_rnd(xl * dry + wl * wet, 16);
        yr = rshift_rnd(xr * dry + wr * wet, 16);
        if (!out_st_q) begin
            yl = rshift_rnd(yl + yr, 1);
            yr = yl;
        end
        y.left  = yl[15:0];
        y.right = yr[15:0];
        chorus_due.push_back(y);
        num = (64'd3276800 + 64'd5950 * rate_q) << 32;
        den = 64'd65536000 * sr;
        inc = (num + den / 2) / den;
        wr_ptr  = wr_ptr + 1'b1;
        lfo_acc = lfo_acc + inc[31:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= 20)
            $display("MISMATCH result %0d: %s", n_recv, what);
    endtask

    // Input driver
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                chorus_frame(frames_todo.pop_front());
                n_sent++;
                tx_gap = pick_gap();
            end
            if (in_if.valid && !in_if.ready) begin
                // hold the offered request
            end else if (tx_gap > 0) begin
                tx_gap--;
                in_if.valid <= 1'b0;
            end else if (frames_todo.size() > 0) begin
                in_if.valid    <= 1'b1;
                in_if.in_left  <= frames_todo[0].left;
                in_if.in_right <= frames_todo[0].right;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once the run is well under way
    int  rx_hold = 0;
    bit  rx_hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (rx_hold > 0)
            rx_hold <= rx_hold - 1;
        else if (!rx_hold_done && n_sent >= 900) begin
            rx_hold      <= 1500;
            rx_hold_done <= 1'b1;
        end
    end

    // Output monitor
    int rx_gap = 0;
    always @(posedge i_clk) begin
        t_frame want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (chorus_due.size() == 0) begin
                    report_mismatch("result arrived with none expected");
                end else begin
                    want = chorus_due.pop_front();
                    if (out_if.out_left !== want.left)
                        report_mismatch($sformatf("out_left: got %0d expected %0d",
                                                  out_if.out_left, want.left));
                    if (out_if.out_right !== want.right)
                        report_mismatch($sformatf("out_right: got %0d expected %0d",
                                                  out_if.out_right, want.right));
                end
                n_recv++;
                rx_gap = pick_gap();
            end
            if (rx_hold > 0) begin
                out_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        wait (frames_todo.size() == 0 && chorus_due.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_cfg++;
        case (idx)
            REG_RATE:   rate_q   = val[15:0];
            REG_DEPTH:  depth_q  = val[15:0];
            REG_MIX:    mix_q    = val[15:0];
            REG_SR:     srate_q  = val[17:0];
            REG_IN_ST:  in_st_q  = val[0];
            REG_OUT_ST: out_st_q = val[0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [15:0] r, logic [15:0] d, logic [15:0] m, logic [17:0] s,
                           logic ist, logic ost);
        wait_idle();
        reg_write(REG_RATE, {16'h0, r});
        reg_write(REG_DEPTH, {16'h0, d});
        reg_write(REG_MIX, {16'h0, m});
        reg_write(REG_SR, {14'h0, s});
        reg_write(REG_IN_ST, {31'h0, ist});
        reg_write(REG_OUT_ST, {31'h0, ost});
    endtask

    task automatic push_frame(logic [15:0] l, logic [15:0] r);
        t_frame f;
        f.left  = l;
        f.right = r;
        frames_todo.push_back(f);
    endtask

    // Mostly random samples with some full-scale values mixed in
    task automatic push_random(int n);
        logic [15:0] l, r;
        for (int k = 0; k < n; k++) begin
            l = 16'($urandom());
            r = 16'($urandom());
            if ($urandom_range(0, 19) == 0) l = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            if ($urandom_range(0, 19) == 0) r = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            push_frame(l, r);
        end
    endtask

    // Stimulus
    initial begin
        rate_q   = RATE_RST;
        depth_q  = DEPTH_RST;
        mix_q    = MIX_RST;
        srate_q  = SR_RST;
        in_st_q  = 1'b1;
        out_st_q = 1'b1;
        for (int k = 0; k < LINE_LEN; k++) begin
            echo_l[k] = '0;
            echo_r[k] = '0;
        end
        wr_ptr  = '0;
        lfo_acc = '0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_if.valid = 1'b0; in_if.in_left = '0; in_if.in_right = '0;
        out_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full-scale and zero samples at reset settings
        push_frame(16'h7FFF, 16'h8000);
        push_frame(16'h8000, 16'h7FFF);
        push_frame(16'h0000, 16'h0000);
        push_frame(16'hFFFF, 16'h0001);
        push_frame(16'h7FFF, 16'h7FFF);
        push_frame(16'h8000, 16'h8000);
        // Extreme settings, first with stereo paths, then with mono input and mono output
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 18'd192000, 1'b1, 1'b1);
        push_frame(16'h7FFF, 16'h8000);
        push_frame(16'h8000, 16'h7FFF);
        set_all(16'h0000, 16'h0000, 16'h0000, 18'd8000, 1'b0, 1'b0);
        push_frame(16'h7FFF, 16'h1234);
        push_frame(16'h8000, 16'h7FFF);
        // Sample rate below and above range; spare addresses ignored
        set_all(16'hFFFF, 16'h0000, 16'hFFFF, 18'd1000, 1'b0, 1'b1);
        reg_write(REG_SPARE_A, 32'hFFFF_FFFF);
        reg_write(REG_SPARE_B, 32'h0000_1234);
        push_frame(16'h4000, 16'hC000);
        push_frame(16'h8000, 16'h7FFF);
        set_all(16'd1234, 16'hFFFF, 16'd20000, 18'h3FFFF, 1'b1, 1'b0);
        push_frame(16'h7FFF, 16'h8000);
        push_frame(16'h0001, 16'hFFFF);

        // Random phases; fast LFO at a low rate forces the phase to wrap
        set_all(16'hFFFF, 16'h8000, 16'hC000, 18'd8000, 1'b1, 1'b1);
        push_random(800);
        set_all(16'd19661, 16'hFFFF, 16'h8000, 18'd48000, 1'b1, 1'b1);
        calm = 1'b1;
        push_random(150);
        wait_idle();
        calm = 1'b0;
        push_random(150);
        for (int ph = 0; ph < 4; ph++) begin
            set_all(16'($urandom()), 16'($urandom()), 16'($urandom()),
                    18'($urandom_range(4000, 200000)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            push_random(230);
        end

        wait_idle();
        repeat (100) @(posedge i_clk);
        $display("Covered %0d frames and %0d results over %0d register writes,", n_sent,
                 n_recv, n_cfg);
        $display("including range extremes, mono paths, rate clamping and phase wrap.");
        if (errors == 0 && chorus_due.size() == 0)
            $display("stereo_chorus_modulated_delay regression: pass");
        else
            $display("stereo_chorus_modulated_delay regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #40ms;
        $display("Timeout with %0d results outstanding", chorus_due.size());
        $display("stereo_chorus_modulated_delay regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
src/scmd_pkg.sv
src/scmd_if.sv
src/scmd_ram.sv
src/scmd_div.sv
src/scmd_regs.sv
src/stereo_chorus_modulated_delay.sv
bench/testbench.sv
